// File: hdl/string_frequency_counter_top_item_assert.svh
// ----------------------------------------------------------------------------
// string_frequency_counter_top_item_assert.svh
// assertion macros shared by the frequency counter rtl
// ----------------------------------------------------------------------------
`ifndef STRING_FREQUENCY_COUNTER_TOP_ITEM_ASSERT_SVH
`define STRING_FREQUENCY_COUNTER_TOP_ITEM_ASSERT_SVH

// property must hold at every clock edge out of reset
`define SFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen out of reset
`define SFC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: hdl/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg
// sizes, result codes and helpers of the frequency counter
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int NAME_BYTES  = 49;
  localparam int COUNT_BITS  = 20;

  localparam int SUPPORT_W   = 20;
  localparam int STATUS_W    = 3;
  localparam int ENT_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int USED_W      = $clog2(MAX_ENTRIES + 1);
  localparam int LEN_W       = $clog2(NAME_BYTES + 1);
  localparam int KEY_AW      = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
  localparam int STORE_DEPTH = MAX_ENTRIES * NAME_BYTES;
  localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [STATUS_W-1:0] {
    ST_EXISTING = 3'd0,
    ST_NEW      = 3'd1,
    ST_FULL     = 3'd2,
    ST_REPORT   = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

endpackage

// File: hdl/sfc_ram.sv
// ----------------------------------------------------------------------------
// sfc_ram
// generic simple dual port ram, one write port, registered read
// ----------------------------------------------------------------------------
module sfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk_i,
  input  logic                                     wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                         wr_data_i,
  input  logic                                     rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// File: hdl/string_frequency_counter_top_item.sv
// ----------------------------------------------------------------------------
// string_frequency_counter_top_item
// frequency count table of byte-serial names with a top item report
// ----------------------------------------------------------------------------
//  channel   dir  tdata                          tuser         tlast
//  s_axis    in   item_byte[7:0]                 req_type      end_of_name
//  m_axis    out  support[19:0], name_byte[27:20] status[2:0]   last
//
// steps: a name byte that is not final is taken in S_IDLE. an end-of-name beat
// scans the table: a length read per stored entry plus a byte read and compare
// per compared byte of each entry of equal length, then a count read and write
// for a count update, or a key read and name write per byte to append a new
// name. a report reads the count of each entry, then the best one's length and
// each of its name bytes. every read goes through the registered single read
// port of each ram. reset: the registers are cleared, among them the entry count
// and key length, but not the rams, which need no clearing pass. stalls: the
// result register holds one beat, the sequencer waits on it only when it has the next beat ready.
module string_frequency_counter_top_item
  import sfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // item_byte[7:0]
  input  logic        s_axis_tuser_i,   // req_type
  input  logic        s_axis_tlast_i,   // end_of_name
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // support[19:0], name_byte[27:20], zero pad
  output logic [2:0]  m_axis_tuser_o,   // status[2:0]
  output logic        m_axis_tlast_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_LEN_RD, S_LEN_CHK, S_BYTE_RD, S_BYTE_CHK, S_CNT_RD, S_CNT_WR,
    S_MISS, S_CP_RD, S_CP_WR, S_RP_RD, S_RP_CHK, S_RL_RD, S_RL_CHK,
    S_RB_RD, S_RB_EMIT, S_EMIT
  } state_e;

  state_e                state_q;
  logic [USED_W-1:0]     used_q;      // valid entries
  logic [LEN_W-1:0]      klen_q;      // bytes of the name in the key buffer
  logic [USED_W-1:0]     ent_q;       // entry under scan
  logic [STORE_AW-1:0]   base_q;      // name store address of ent_q
  logic [LEN_W-1:0]      idx_q;       // byte index within a name
  logic [ENT_W-1:0]      best_q;
  logic [STORE_AW-1:0]   bbase_q;
  logic [COUNT_BITS-1:0] best_cnt_q;
  logic [LEN_W-1:0]      rlen_q;      // length of the reported name
  status_e               res_st_q;    // pending single result
  logic [COUNT_BITS-1:0] res_cnt_q;

  logic                  out_valid_q;
  status_e               out_st_q;
  logic [SUPPORT_W-1:0]  out_sup_q;
  logic [7:0]            out_byte_q;
  logic                  out_last_q;

  // ram ports
  logic                  nm_we, nm_re;
  logic [STORE_AW-1:0]   nm_wa, nm_ra;
  logic [7:0]            nm_rd;
  logic                  ln_we, ln_re;
  logic [ENT_W-1:0]      ln_wa, ln_ra;
  logic [LEN_W-1:0]      ln_rd;
  logic                  ct_we, ct_re;
  logic [ENT_W-1:0]      ct_wa, ct_ra;
  logic [COUNT_BITS-1:0] ct_wd, ct_rd;
  logic                  ky_we, ky_re;
  logic [KEY_AW-1:0]     ky_wa, ky_ra;
  logic [7:0]            ky_rd;

  logic                  in_acc;
  logic                  slot_free;
  logic                  idx_last;
  logic [COUNT_BITS-1:0] cnt_inc;

  assign in_acc    = s_axis_tvalid_i & s_axis_tready_o;
  assign slot_free = ~out_valid_q | m_axis_tready_i;
  assign idx_last  = (idx_q + LEN_W'(1)) == klen_q;
  assign cnt_inc   = (ct_rd == COUNT_MAX) ? ct_rd : ct_rd + COUNT_BITS'(1);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_st_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {4'd0, out_byte_q, out_sup_q};

  // ram address and enable steering per sequencer state
  always_comb begin
    nm_we = 1'b0; nm_re = 1'b0;
    nm_wa = base_q + STORE_AW'(idx_q);
    nm_ra = base_q + STORE_AW'(idx_q);
    ln_we = 1'b0; ln_re = 1'b0;
    ln_wa = ent_q[ENT_W-1:0];
    ln_ra = ent_q[ENT_W-1:0];
    ct_we = 1'b0; ct_re = 1'b0;
    ct_wa = ent_q[ENT_W-1:0];
    ct_ra = ent_q[ENT_W-1:0];
    ct_wd = cnt_inc;
    ky_we = 1'b0; ky_re = 1'b0;
    ky_wa = klen_q[KEY_AW-1:0];
    ky_ra = idx_q[KEY_AW-1:0];
    unique case (state_q)
      S_IDLE:    ky_we = in_acc & ~s_axis_tuser_i & (klen_q < LEN_W'(NAME_BYTES));
      S_LEN_RD:  ln_re = 1'b1;
      S_BYTE_RD: begin
        nm_re = 1'b1;
        ky_re = 1'b1;
      end
      S_CNT_RD:  ct_re = 1'b1;
      S_CNT_WR:  ct_we = 1'b1;
      S_CP_RD:   ky_re = 1'b1;
      S_CP_WR: begin
        nm_we = 1'b1;
        ln_we = idx_last;
        ct_we = idx_last;
        ct_wd = COUNT_BITS'(1);
      end
      S_RP_RD:   ct_re = 1'b1;
      S_RL_RD: begin
        ln_re = 1'b1;
        ln_ra = best_q;
      end
      S_RB_RD: begin
        nm_re = 1'b1;
        nm_ra = bbase_q + STORE_AW'(idx_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      klen_q      <= '0;
      ent_q       <= '0;
      base_q      <= '0;
      idx_q       <= '0;
      best_q      <= '0;
      bbase_q     <= '0;
      best_cnt_q  <= '0;
      rlen_q      <= '0;
      res_st_q    <= ST_EMPTY;
      res_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      out_st_q    <= ST_EMPTY;
      out_sup_q   <= '0;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            ent_q  <= '0;
            base_q <= '0;
            if (s_axis_tuser_i) begin
              best_cnt_q <= '0;
              best_q     <= '0;
              bbase_q    <= '0;
              if (used_q == '0) begin
                res_st_q  <= ST_EMPTY;
                res_cnt_q <= '0;
                state_q   <= S_EMIT;
              end else begin
                state_q <= S_RP_RD;
              end
            end else begin
              if (klen_q < LEN_W'(NAME_BYTES)) begin
                klen_q <= klen_q + LEN_W'(1);
              end
              if (s_axis_tlast_i) begin
                state_q <= S_LEN_RD;
              end
            end
          end
        end
        S_LEN_RD: state_q <= (ent_q == used_q) ? S_MISS : S_LEN_CHK;
        S_LEN_CHK: begin
          if (ln_rd == klen_q) begin
            idx_q   <= '0;
            state_q <= S_BYTE_RD;
          end else begin
            ent_q   <= ent_q + USED_W'(1);
            base_q  <= base_q + STORE_AW'(NAME_BYTES);
            state_q <= S_LEN_RD;
          end
        end
        S_BYTE_RD: state_q <= S_BYTE_CHK;
        S_BYTE_CHK: begin
          priority if (nm_rd != ky_rd) begin
            ent_q   <= ent_q + USED_W'(1);
            base_q  <= base_q + STORE_AW'(NAME_BYTES);
            state_q <= S_LEN_RD;
          end else if (idx_last) begin
            state_q <= S_CNT_RD;
          end else begin
            idx_q   <= idx_q + LEN_W'(1);
            state_q <= S_BYTE_RD;
          end
        end
        S_CNT_RD: state_q <= S_CNT_WR;
        S_CNT_WR: begin
          res_st_q  <= ST_EXISTING;
          res_cnt_q <= cnt_inc;
          klen_q    <= '0;
          state_q   <= S_EMIT;
        end
        S_MISS: begin
          if (used_q < USED_W'(MAX_ENTRIES)) begin
            idx_q   <= '0;
            state_q <= S_CP_RD;
          end else begin
            res_st_q  <= ST_FULL;
            res_cnt_q <= '0;
            klen_q    <= '0;
            state_q   <= S_EMIT;
          end
        end
        S_CP_RD: state_q <= S_CP_WR;
        S_CP_WR: begin
          if (idx_last) begin
            used_q    <= used_q + USED_W'(1);
            res_st_q  <= ST_NEW;
            res_cnt_q <= COUNT_BITS'(1);
            klen_q    <= '0;
            state_q   <= S_EMIT;
          end else begin
            idx_q   <= idx_q + LEN_W'(1);
            state_q <= S_CP_RD;
          end
        end
        S_RP_RD: state_q <= S_RP_CHK;
        S_RP_CHK: begin
          // strict compare keeps the earliest entry on a tie
          if (ct_rd > best_cnt_q) begin
            best_cnt_q <= ct_rd;
            best_q     <= ent_q[ENT_W-1:0];
            bbase_q    <= base_q;
          end
          if (ent_q + USED_W'(1) == used_q) begin
            state_q <= S_RL_RD;
          end else begin
            ent_q   <= ent_q + USED_W'(1);
            base_q  <= base_q + STORE_AW'(NAME_BYTES);
            state_q <= S_RP_RD;
          end
        end
        S_RL_RD: state_q <= S_RL_CHK;
        S_RL_CHK: begin
          rlen_q  <= ln_rd;
          idx_q   <= '0;
          state_q <= S_RB_RD;
        end
        S_RB_RD: state_q <= S_RB_EMIT;
        S_RB_EMIT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_st_q    <= ST_REPORT;
            out_sup_q   <= SUPPORT_W'(best_cnt_q);
            out_byte_q  <= nm_rd;
            out_last_q  <= (idx_q + LEN_W'(1)) == rlen_q;
            if ((idx_q + LEN_W'(1)) == rlen_q) begin
              state_q <= S_IDLE;
            end else begin
              idx_q   <= idx_q + LEN_W'(1);
              state_q <= S_RB_RD;
            end
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_st_q    <= res_st_q;
            out_sup_q   <= SUPPORT_W'(res_cnt_q);
            out_byte_q  <= '0;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  sfc_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_name_ram (
    .clk_i, .wr_en_i(nm_we), .wr_addr_i(nm_wa), .wr_data_i(ky_rd),
    .rd_en_i(nm_re), .rd_addr_i(nm_ra), .rd_data_o(nm_rd)
  );

  sfc_ram #(.WIDTH(LEN_W), .DEPTH(MAX_ENTRIES)) u_len_ram (
    .clk_i, .wr_en_i(ln_we), .wr_addr_i(ln_wa), .wr_data_i(klen_q),
    .rd_en_i(ln_re), .rd_addr_i(ln_ra), .rd_data_o(ln_rd)
  );

  sfc_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_ENTRIES)) u_cnt_ram (
    .clk_i, .wr_en_i(ct_we), .wr_addr_i(ct_wa), .wr_data_i(ct_wd),
    .rd_en_i(ct_re), .rd_addr_i(ct_ra), .rd_data_o(ct_rd)
  );

  sfc_ram #(.WIDTH(8), .DEPTH(NAME_BYTES)) u_key_ram (
    .clk_i, .wr_en_i(ky_we), .wr_addr_i(ky_wa), .wr_data_i(s_axis_tdata_i),
    .rd_en_i(ky_re), .rd_addr_i(ky_ra), .rd_data_o(ky_rd)
  );

`include "string_frequency_counter_top_item_assert.svh"

  `SFC_ASSERT_NEVER(a_used_bound, used_q > USED_W'(MAX_ENTRIES), "entry count overflow")
  `SFC_ASSERT_NEVER(a_klen_bound, klen_q > LEN_W'(NAME_BYTES), "key length overflow")
  `SFC_ASSERT(a_new_grows, (state_q == S_CP_WR && idx_last) |=> (used_q == $past(used_q) + USED_W'(1)), "append did not grow table")
  `SFC_ASSERT_NEVER(a_rep_len, state_q == S_RB_EMIT && rlen_q == '0, "report of empty name")

endmodule

// File: tb/sv/tb_sfc_checker.sv
// ----------------------------------------------------------------------------
// tb_sfc_checker
// watches both stream channels, keeps its own copy of the frequency table and
// compares every output beat with the oldest predicted result
// ----------------------------------------------------------------------------
module tb_sfc_checker
  import sfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,
  input  logic        s_axis_tuser_i,
  input  logic        s_axis_tlast_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [31:0] m_axis_tdata_i,
  input  logic [2:0]  m_axis_tuser_i,
  input  logic        m_axis_tlast_i,
  output int          errors_o,
  output int          pending_o,
  output int          checked_o,
  output int          full_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e              status;
    logic [SUPPORT_W-1:0] support;
    logic [7:0]           name_byte;
    logic                 last;
  } result_t;

  result_t   expected_q[$];
  logic [7:0] names [MAX_ENTRIES][NAME_BYTES];
  int         name_len [MAX_ENTRIES];
  logic [COUNT_BITS-1:0] tally [MAX_ENTRIES];
  int         entries;
  logic [7:0] key [NAME_BYTES];
  int         key_len;
  int         errors;
  int         checked;
  int         full_seen;

  assign errors_o    = errors;
  assign pending_o   = expected_q.size();
  assign checked_o   = checked;
  assign full_seen_o = full_seen;

  function automatic result_t mk(status_e st, logic [SUPPORT_W-1:0] sup,
                                 logic [7:0] b, logic l);
    result_t r;
    r.status = st; r.support = sup; r.name_byte = b; r.last = l;
    return r;
  endfunction

  // update the table with one accepted input beat and queue its results
  task automatic count_beat(logic req, logic [7:0] b, logic eon);
    int best;
    logic [COUNT_BITS-1:0] best_cnt;
    bit hit;
    if (req) begin
      if (entries == 0) begin
        expected_q.push_back(mk(ST_EMPTY, '0, '0, 1'b1));
        return;
      end
      best = 0;
      best_cnt = '0;
      for (int e = 0; e < entries; e++)
        if (tally[e] > best_cnt) begin
          best_cnt = tally[e];
          best = e;
        end
      for (int i = 0; i < name_len[best]; i++)
        expected_q.push_back(mk(ST_REPORT, best_cnt, names[best][i],
                                i + 1 == name_len[best]));
      return;
    end
    if (key_len < NAME_BYTES) begin
      key[key_len] = b;
      key_len++;
    end
    if (!eon) return;
    for (int e = 0; e < entries; e++) begin
      hit = (name_len[e] == key_len);
      for (int i = 0; hit && i < key_len; i++)
        if (names[e][i] != key[i]) hit = 0;
      if (hit) begin
        if (tally[e] != COUNT_MAX) tally[e]++;
        expected_q.push_back(mk(ST_EXISTING, tally[e], '0, 1'b1));
        key_len = 0;
        return;
      end
    end
    if (entries < MAX_ENTRIES) begin
      for (int i = 0; i < key_len; i++) names[entries][i] = key[i];
      name_len[entries] = key_len;
      tally[entries] = 1;
      entries++;
      expected_q.push_back(mk(ST_NEW, 1, '0, 1'b1));
    end else begin
      full_seen++;
      expected_q.push_back(mk(ST_FULL, '0, '0, 1'b1));
    end
    key_len = 0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, want;
    if (!rst_ni) begin
      expected_q.delete();
      entries   <= 0;
      key_len   <= 0;
      errors    <= 0;
      checked   <= 0;
      full_seen <= 0;
    end else begin
      // results first: they belong to beats accepted at earlier edges
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = mk(status_e'(m_axis_tuser_i), m_axis_tdata_i[19:0],
                 m_axis_tdata_i[27:20], m_axis_tlast_i);
        checked++;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat %h", $time, got);
        end else begin
          want = expected_q.pop_front();
          if (got != want || m_axis_tdata_i[31:28] != 4'h0) begin
            errors++;
            $display("%0t: mismatch expected st=%0d sup=%0d byte=%h last=%b",
                     $time, want.status, want.support, want.name_byte, want.last);
            $display("%0t:          actual   st=%0d sup=%0d byte=%h last=%b pad=%h",
                     $time, got.status, got.support, got.name_byte, got.last,
                     m_axis_tdata_i[31:28]);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        count_beat(s_axis_tuser_i, s_axis_tdata_i, s_axis_tlast_i);
    end
  end

endmodule

// File: tb/sv/tb_string_frequency_counter_top_item.sv
// ----------------------------------------------------------------------------
// tb_string_frequency_counter_top_item
// stimulus and verdict for the frequency counter: directed names and reports,
// then random name streams under several idle and stall mixes
// ----------------------------------------------------------------------------
module tb_string_frequency_counter_top_item;
  import sfc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400_000;     // far above a full run
  localparam int POOL        = 10;
  localparam int MAX_LEN     = 56;          // a bit beyond the name store

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // item_byte[7:0]
  logic        s_axis_tuser = 1'b0; // req_type
  logic        s_axis_tlast = 1'b0; // end_of_name
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // support[19:0], name_byte[27:20]
  logic [2:0]  m_axis_tuser;        // status[2:0]
  logic        m_axis_tlast;

  int errors, pending, checked, full_seen;
  int idle_pct  = 0;   // sender idle chance per cycle
  int stall_pct = 0;   // receiver stall chance per cycle
  int beats_sent = 0;
  longint cycles = 0;

  // pool of names reused by the random part so that entries get hit often
  logic [7:0] pool_name [POOL][MAX_LEN];
  int         pool_len  [POOL];

  always #5 clk_i = ~clk_i;

  string_frequency_counter_top_item dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_axis_tvalid), .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i(s_axis_tdata), .s_axis_tuser_i(s_axis_tuser),
    .s_axis_tlast_i(s_axis_tlast),
    .m_axis_tvalid_o(m_axis_tvalid), .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o(m_axis_tdata), .m_axis_tuser_o(m_axis_tuser),
    .m_axis_tlast_o(m_axis_tlast)
  );

  tb_sfc_checker checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_axis_tvalid), .s_axis_tready_i(s_axis_tready),
    .s_axis_tdata_i(s_axis_tdata), .s_axis_tuser_i(s_axis_tuser),
    .s_axis_tlast_i(s_axis_tlast),
    .m_axis_tvalid_i(m_axis_tvalid), .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_i(m_axis_tdata), .m_axis_tuser_i(m_axis_tuser),
    .m_axis_tlast_i(m_axis_tlast),
    .errors_o(errors), .pending_o(pending), .checked_o(checked),
    .full_seen_o(full_seen)
  );

  // receiver side back-pressure, redrawn every cycle
  always @(posedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= stall_pct);

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // one input beat; valid stays high afterwards unless the next call idles
  task automatic send(logic req, logic [7:0] b, logic eon);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eon;
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
  endtask

  task automatic send_pool(int p);
    for (int i = 0; i < pool_len[p]; i++) begin
      // now and then a report lands in the middle of a name
      if (i > 0 && $urandom_range(19) == 0) send(1'b1, 8'($urandom), 1'($urandom));
      send(1'b0, pool_name[p][i], i + 1 == pool_len[p]);
    end
  endtask

  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0] long_name [MAX_LEN];
    int len;
    for (int p = 0; p < POOL; p++) begin
      pool_len[p] = (p == 0) ? MAX_LEN : (p == 1) ? 1 : $urandom_range(1, MAX_LEN);
      for (int i = 0; i < MAX_LEN; i++) pool_name[p][i] = 8'($urandom);
    end
    for (int i = 0; i < MAX_LEN; i++) long_name[i] = 8'($urandom);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty report, byte extremes, truncation, report mid-name
    send(1'b1, 8'hFF, 1'b1);              // report on an empty table
    send(1'b0, 8'h00, 1'b1);              // one-byte name 00, new
    send(1'b0, 8'hFF, 1'b1);              // one-byte name ff, new
    send(1'b0, 8'hFF, 1'b1);              // ff again, counted
    send(1'b1, 8'h00, 1'b0);              // report: ff wins
    send(1'b0, 8'h00, 1'b1);              // 00 again: tie, earliest wins
    send(1'b1, 8'h00, 1'b0);
    for (int i = 0; i < MAX_LEN; i++)     // too long, stored truncated
      send(1'b0, long_name[i], i == MAX_LEN - 1);
    send(1'b0, 8'hA5, 1'b0);
    send(1'b1, 8'h5A, 1'b1);              // report with a partial name held
    send(1'b0, 8'h5A, 1'b1);              // name a5 5a completes
    for (int i = 0; i < NAME_BYTES; i++)  // exact prefix hits the long entry
      send(1'b0, long_name[i], i == NAME_BYTES - 1);
    for (int i = 0; i < NAME_BYTES; i++)
      send(1'b0, long_name[i], i == NAME_BYTES - 1);
    send(1'b1, 8'h00, 1'b0);              // report of the 49-byte name
    quiesce();

    // random names under four idle/stall mixes
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 68 : 28) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 68 : 28) : 0;
      for (int n = beats_sent + 45; beats_sent < n; ) begin
        case ($urandom_range(9))
          0: send(1'b1, 8'($urandom), 1'($urandom));
          1: begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) send(1'b0, 8'($urandom), i == len - 1);
          end
          default: send_pool($urandom_range(POOL - 1));
        endcase
      end
      quiesce();
    end

    $display("sent %0d input beats, checked %0d result beats", beats_sent, checked);
    $display("names dropped on a full table: %0d", full_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
